>>> design/csp_pkg.sv
`default_nettype none

package csp_pkg;

    localparam int CSP_PIXEL_BITS      = 8;
    localparam int CSP_MAX_LINE_HEIGHT = 8;

    localparam int ROW_W     = 12;
    localparam int COL_W     = 12;
    localparam int LH_W      = 4;
    localparam int FH_W      = 13;
    localparam int Q8_W      = 9;
    localparam int BRIGHT_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam int SCAN_N    = 8;
    localparam int SCAN_W    = 17;
    localparam int LEVEL_W   = 25;
    localparam int ROWGAIN_W = 18;
    localparam int FLIP_W    = 14;
    localparam int WEIGHT_W  = 9;

    localparam int NUM_CHAN  = 4;
    localparam int CH_RED    = 0;
    localparam int CH_GREEN  = 1;
    localparam int CH_BLUE   = 2;
    localparam int CH_ALPHA  = 3;

    localparam logic [Q8_W-1:0]      UNIT_Q8    = Q8_W'(256);
    localparam logic [BRIGHT_W-1:0]  MAX_BRIGHT = BRIGHT_W'(512);
    localparam logic [SCAN_W-1:0]    SCAN_ONE   = SCAN_W'(65536);
    localparam logic [LEVEL_W-1:0]   LEVEL_ONE  = LEVEL_W'(1 << 24);
    localparam logic [ROWGAIN_W-1:0] MAX_GAIN   = ROWGAIN_W'(1 << 17);

    // multiple of lcm(1..8) = 840, large enough to keep the flipped row positive
    localparam int ROW_BIAS = 840 * 5;

    localparam logic [SCAN_W-1:0] SCAN_TABLE [SCAN_N][SCAN_N] = '{
        '{17'd65536, 17'd0,     17'd0,     17'd0,    17'd0,
          17'd0,     17'd0,     17'd0},
        '{17'd65536, 17'd0,     17'd0,     17'd0,    17'd0,
          17'd0,     17'd0,     17'd0},
        '{17'd65536, 17'd16384, 17'd16384, 17'd0,    17'd0,
          17'd0,     17'd0,     17'd0},
        '{17'd65536, 17'd32768, 17'd0,     17'd32768, 17'd0,
          17'd0,     17'd0,     17'd0},
        '{17'd65536, 17'd42894, 17'd6258,  17'd6258, 17'd42894,
          17'd0,     17'd0,     17'd0},
        '{17'd65536, 17'd49152, 17'd16384, 17'd0,    17'd16384,
          17'd49152, 17'd0,     17'd0},
        '{17'd65536, 17'd53199, 17'd25476, 17'd3245, 17'd3245,
          17'd25476, 17'd53199, 17'd0},
        '{17'd65536, 17'd55938, 17'd32768, 17'd9598, 17'd0,
          17'd9598,  17'd32768, 17'd55938}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_HEIGHT  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_STRENGTH     = 3'd2,
        CFG_TRIAD        = 3'd3,
        CFG_BRIGHTNESS   = 3'd4,
        CFG_MIX_AMOUNT   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           phase;
        logic [ROWGAIN_W-1:0] gain;
    } csp_front_t;

    function automatic logic [Q8_W-1:0] sat_q8(input logic [Q8_W-1:0] v);
        return (v > UNIT_Q8) ? UNIT_Q8 : v;
    endfunction

endpackage

`default_nettype wire

>>> design/csp_row_gain.sv
`default_nettype none

module csp_row_gain
    import csp_pkg::*;
#(
    parameter int PIXEL_BITS = CSP_PIXEL_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [ROW_W-1:0]      row,
    input  wire logic [COL_W-1:0]      column,
    input  wire logic [PIXEL_BITS-1:0] chan_in [NUM_CHAN],
    input  wire logic [LH_W-1:0]       line_height,
    input  wire logic [FH_W-1:0]       frame_height,
    input  wire logic [Q8_W-1:0]       strength,
    input  wire logic [BRIGHT_W-1:0]   brightness,
    output csp_front_t                 front,
    output logic [PIXEL_BITS-1:0]      chan_out [NUM_CHAN]
);

    // one remainder step per bit, bits taken msb first
    function automatic logic [2:0] mod_bits(input logic [2:0] r_in,
                                            input logic [6:0] bits,
                                            input logic [3:0] n);
        logic [3:0] r;
        r = {1'b0, r_in};
        for (int i = 6; i >= 0; i--) begin
            r = {r[2:0], bits[i]};
            if (r >= n)
                r = r - n;
        end
        return r[2:0];
    endfunction

    // 4 = 1 mod 3, so base-4 digits sum to the same residue
    function automatic logic [4:0] digit_sum(input logic [COL_W-1:0] c);
        logic [4:0] s;
        s = '0;
        for (int i = 0; i < COL_W / 2; i++)
            s = s + 5'(c[2*i +: 2]);
        return s;
    endfunction

    function automatic logic [1:0] mod3(input logic [4:0] s);
        logic [4:0] r;
        r = s;
        for (int i = 0; i < 6; i++) begin
            if (r >= 5'd3)
                r = r - 5'd3;
        end
        return r[1:0];
    endfunction

    logic [3:0]          n;
    logic [2:0]          n_idx;
    logic [Q8_W-1:0]     s_sat;
    logic [BRIGHT_W-1:0] b_sat;
    logic [FLIP_W-1:0]   flip;

    logic                 valid_s1_reg, valid_s2_reg, valid_s3_reg, valid_s4_reg;
    logic [2:0]           rmod_s1_reg;
    logic [6:0]           ulow_s1_reg;
    logic [4:0]           csum_s1_reg;
    logic [2:0]           k_s2_reg;
    logic [1:0]           phase_s2_reg, phase_s3_reg, phase_s4_reg;
    logic [LEVEL_W-1:0]   level_s3_reg;
    logic [ROWGAIN_W-1:0] gain_s4_reg;
    logic [PIXEL_BITS-1:0] chan_s1_reg [NUM_CHAN];
    logic [PIXEL_BITS-1:0] chan_s2_reg [NUM_CHAN];
    logic [PIXEL_BITS-1:0] chan_s3_reg [NUM_CHAN];
    logic [PIXEL_BITS-1:0] chan_s4_reg [NUM_CHAN];

    logic [SCAN_W-1:0]         scan;
    logic [SCAN_W-1:0]         depth;
    logic [LEVEL_W+1:0]        dark;
    logic [LEVEL_W-1:0]        level_next;
    logic [LEVEL_W+BRIGHT_W-1:0] scaled;
    logic [ROWGAIN_W-1:0]      gain_next;

    always_comb
    begin
        if (line_height == '0)
            n = 4'd1;
        else if (line_height > 4'(CSP_MAX_LINE_HEIGHT))
            n = 4'(CSP_MAX_LINE_HEIGHT);
        else
            n = line_height;
        if (n > 4'(SCAN_N))
            n = 4'(SCAN_N);
        n_idx = 3'(n - 4'd1);
        s_sat = sat_q8(strength);
        b_sat = (brightness > MAX_BRIGHT) ? MAX_BRIGHT : brightness;
        flip  = FLIP_W'(frame_height) + FLIP_W'(ROW_BIAS - 1) - FLIP_W'(row);
    end

    always_comb
    begin
        scan       = SCAN_TABLE[n_idx][k_s2_reg];
        depth      = SCAN_ONE - scan;
        dark       = (LEVEL_W + 2)'(s_sat) * (LEVEL_W + 2)'(depth);
        level_next = LEVEL_W'(LEVEL_ONE - dark[LEVEL_W-1:0]);
        scaled     = (LEVEL_W + BRIGHT_W)'(level_s3_reg) * (LEVEL_W + BRIGHT_W)'(b_sat)
                     + (LEVEL_W + BRIGHT_W)'(1 << 15);
        gain_next  = scaled[16 +: ROWGAIN_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
            valid_s4_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= accept;
            valid_s2_reg <= valid_s1_reg;
            valid_s3_reg <= valid_s2_reg;
            valid_s4_reg <= valid_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rmod_s1_reg  <= mod_bits(3'd0, flip[13:7], n);
        ulow_s1_reg  <= flip[6:0];
        csum_s1_reg  <= digit_sum(column);
        k_s2_reg     <= mod_bits(rmod_s1_reg, ulow_s1_reg, n);
        phase_s2_reg <= mod3(csum_s1_reg);
        level_s3_reg <= level_next;
        phase_s3_reg <= phase_s2_reg;
        gain_s4_reg  <= gain_next;
        phase_s4_reg <= phase_s3_reg;
        chan_s1_reg  <= chan_in;
        chan_s2_reg  <= chan_s1_reg;
        chan_s3_reg  <= chan_s2_reg;
        chan_s4_reg  <= chan_s3_reg;
    end

    assign front.valid = valid_s4_reg;
    assign front.phase = phase_s4_reg;
    assign front.gain  = gain_s4_reg;
    assign chan_out    = chan_s4_reg;

endmodule

`default_nettype wire

>>> design/csp_lane.sv
`default_nettype none

module csp_lane
    import csp_pkg::*;
#(
    parameter int PIXEL_BITS = CSP_PIXEL_BITS
) (
    input  wire logic                  clk,
    input  wire logic [PIXEL_BITS-1:0] c,
    input  wire logic [ROWGAIN_W-1:0]  gain,
    input  wire logic                  is_phase,
    input  wire logic [Q8_W-1:0]       triad,
    input  wire logic [Q8_W-1:0]       mix,
    output logic      [PIXEL_BITS-1:0] result
);

    localparam int CG_W = PIXEL_BITS + ROWGAIN_W;
    localparam int O_W  = CG_W + WEIGHT_W;
    localparam int BW   = PIXEL_BITS + 34;
    localparam int CI_W = PIXEL_BITS + Q8_W;
    localparam int R_W  = BW - 32;

    logic [CG_W-1:0]       cg_reg;
    logic [WEIGHT_W-1:0]   w_reg;
    logic [PIXEL_BITS-1:0] c1_reg, c2_reg;
    logic [O_W-1:0]        o_reg;
    logic [BW-1:0]         om_reg;
    logic [CI_W-1:0]       ci_reg;

    logic [O_W+Q8_W-1:0]   om_next;
    logic [BW-1:0]         blend;
    logic [R_W-1:0]        rnd;

    assign om_next = (O_W + Q8_W)'(o_reg) * (O_W + Q8_W)'(mix);

    always_ff @(posedge clk)
    begin
        cg_reg <= CG_W'(c) * CG_W'(gain);
        w_reg  <= is_phase ? UNIT_Q8 : UNIT_Q8 - triad;
        c1_reg <= c;
        o_reg  <= O_W'(cg_reg) * O_W'(w_reg);
        c2_reg <= c1_reg;
        om_reg <= om_next[BW-1:0];
        ci_reg <= CI_W'(c2_reg) * CI_W'(UNIT_Q8 - mix);
    end

    always_comb
    begin
        blend = (BW'(ci_reg) << 24) + om_reg + (BW'(1) << 31);
        rnd   = blend[BW-1:32];
        if (rnd > R_W'({PIXEL_BITS{1'b1}}))
            result = {PIXEL_BITS{1'b1}};
        else
            result = rnd[PIXEL_BITS-1:0];
    end

endmodule

`default_nettype wire

>>> design/crt_scanline_triad_pixel_unit.sv
// CRT scanline and phosphor triad pixel filter.
// Pixel channel: a request (row, column, red/green/blue/alpha) is taken at a
// rising edge with start high and busy low. busy stays low: a new pixel may
// be issued every clock.
// Result channel: strobe is high for one cycle with red/green/blue/alpha_out;
// the receiver cannot stall, so the pipeline never holds.
// Pipeline: the request passes 4 row/gain stages, 3 lane stages and 1 output
// register before its result is shown with strobe.
// Throughput: one pixel per cycle. The row-gain front end computes the flipped
// row residue bit-serially over two stages, then the scan level and row gain;
// three color lanes apply gain, triad weight and mix; the output register
// merges the lanes with alpha.
// Configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data;
// cfg_ready is always high. Write only while no pixel is in flight.
// Reset: rst_n clears the pipeline valid bits and loads register defaults;
// pixels in flight are dropped.
`default_nettype none

module crt_scanline_triad_pixel_unit
    import csp_pkg::*;
#(
    parameter int PIXEL_BITS = CSP_PIXEL_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ROW_W-1:0]      row,
    input  wire logic [COL_W-1:0]      column,
    input  wire logic [PIXEL_BITS-1:0] red_in,
    input  wire logic [PIXEL_BITS-1:0] green_in,
    input  wire logic [PIXEL_BITS-1:0] blue_in,
    input  wire logic [PIXEL_BITS-1:0] alpha_in,
    output logic                       strobe,
    output logic [PIXEL_BITS-1:0]      red_out,
    output logic [PIXEL_BITS-1:0]      green_out,
    output logic [PIXEL_BITS-1:0]      blue_out,
    output logic [PIXEL_BITS-1:0]      alpha_out,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

    localparam int LANES = 3;

    logic                  accept;
    logic [LH_W-1:0]       line_height_reg;
    logic [FH_W-1:0]       frame_height_reg;
    logic [Q8_W-1:0]       strength_reg;
    logic [Q8_W-1:0]       triad_reg;
    logic [BRIGHT_W-1:0]   brightness_reg;
    logic [Q8_W-1:0]       mix_reg;
    logic [Q8_W-1:0]       triad_sat;
    logic [Q8_W-1:0]       mix_sat;

    logic [PIXEL_BITS-1:0] chan_in   [NUM_CHAN];
    logic [PIXEL_BITS-1:0] chan_front[NUM_CHAN];
    logic [PIXEL_BITS-1:0] lane_result[LANES];
    csp_front_t            front;

    logic [2:0]            lane_vld_reg;
    logic [PIXEL_BITS-1:0] alpha_pipe_reg [3];
    logic                  strobe_reg;
    logic [PIXEL_BITS-1:0] red_reg, green_reg, blue_reg, alpha_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign chan_in[CH_RED]   = red_in;
    assign chan_in[CH_GREEN] = green_in;
    assign chan_in[CH_BLUE]  = blue_in;
    assign chan_in[CH_ALPHA] = alpha_in;

    assign triad_sat = sat_q8(triad_reg);
    assign mix_sat   = sat_q8(mix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_height_reg  <= LH_W'(3);
            frame_height_reg <= FH_W'(1);
            strength_reg     <= Q8_W'(128);
            triad_reg        <= '0;
            brightness_reg   <= BRIGHT_W'(294);
            mix_reg          <= UNIT_Q8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINE_HEIGHT:  line_height_reg  <= cfg_data[LH_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                CFG_STRENGTH:     strength_reg     <= cfg_data[Q8_W-1:0];
                CFG_TRIAD:        triad_reg        <= cfg_data[Q8_W-1:0];
                CFG_BRIGHTNESS:   brightness_reg   <= cfg_data[BRIGHT_W-1:0];
                CFG_MIX_AMOUNT:   mix_reg          <= cfg_data[Q8_W-1:0];
                default: ;
            endcase
        end
    end

    csp_row_gain #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_row_gain (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .row          (row),
        .column       (column),
        .chan_in      (chan_in),
        .line_height  (line_height_reg),
        .frame_height (frame_height_reg),
        .strength     (strength_reg),
        .brightness   (brightness_reg),
        .front        (front),
        .chan_out     (chan_front)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        csp_lane #(
            .PIXEL_BITS(PIXEL_BITS)
        ) u_lane (
            .clk      (clk),
            .c        (chan_front[g]),
            .gain     (front.gain),
            .is_phase (front.phase == 2'(g)),
            .triad    (triad_sat),
            .mix      (mix_sat),
            .result   (lane_result[g])
        );
    end

    // merge: lanes and alpha into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_vld_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            lane_vld_reg <= {lane_vld_reg[1:0], front.valid};
            strobe_reg   <= lane_vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_pipe_reg[0] <= chan_front[CH_ALPHA];
        alpha_pipe_reg[1] <= alpha_pipe_reg[0];
        alpha_pipe_reg[2] <= alpha_pipe_reg[1];
        red_reg           <= lane_result[CH_RED];
        green_reg         <= lane_result[CH_GREEN];
        blue_reg          <= lane_result[CH_BLUE];
        alpha_reg         <= alpha_pipe_reg[2];
    end

    assign strobe    = strobe_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign alpha_out = alpha_reg;

`ifndef SYNTHESIS
    a_strobe_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy, 8))
        else $error("result without a request eight cycles earlier");

    a_alpha_through: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> alpha_out == $past(alpha_in, 8))
        else $error("alpha not aligned with its request");

    a_no_mix_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && $past(mix_reg, 2) == '0) |-> red_out == $past(red_in, 8))
        else $error("zero mix did not return the input red");

    a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
        front.valid |-> (front.phase != 2'd3 && front.gain <= MAX_GAIN))
        else $error("row gain or phase out of range");
`endif

endmodule

`default_nettype wire
